// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, skipped while rst is high.
`define UFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop on every rising edge of clk, reset cycles included.
`define UFD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Shared types, codes and helpers of the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package ufd_pkg;

   localparam int unsigned FIELD_BYTES_DEF = 2;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [7:0] SYNC_FIRST  = 8'hEF;
   localparam logic [7:0] SYNC_SECOND = 8'hFE;

   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_TAIL_OK  = 2'd1;
   localparam logic [1:0] KIND_TAIL_BAD = 2'd2;

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_SOURCE  = 3'd1,
      OP_DEST    = 3'd2,
      OP_COMMAND = 3'd3,
      OP_LENGTH  = 3'd4,
      OP_PAYLOAD = 3'd5,
      OP_TAIL    = 3'd6
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  data;
      logic [15:0] index;
      logic        last;
   } entry_type;

   // Place a little-endian byte into a 16-bit word; bytes above bit 15 drop.
   function automatic logic [15:0] insert_byte(input logic [15:0] word,
                                               input logic [7:0]  b,
                                               input logic [15:0] pos);
      logic [15:0] res;
      res = word;
      case (pos)
         16'd0:   res = {word[15:8], b};
         16'd1:   res = {b, word[7:0]};
         default: res = word;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/uart_frame_deframer.sv
// ----------------------------------------------------------------------------
// uart_frame_deframer
// Byte-stream frame deframer: sync, header words, payload beats and tail check.
// ----------------------------------------------------------------------------
// Takes one received byte per beat and sustains one beat per clock cycle while
// the queue is not full. The front stage updates the frame phase and writes at
// most one op per byte into a four-entry queue; the back stage applies each op
// to the header words and loads the result register, so a byte's result passes
// a queue entry and then the result register, which holds while rsp_ready is
// low. Payload bytes come out one result per byte with their offset; the last
// tail byte gives one good-tail or bad-tail result carrying the header words.
// Write csr_wr_data (the expected tail word) only while no frame is in flight.
`default_nettype none

module uart_frame_deframer #(
   parameter int unsigned FIELD_BYTES = ufd_pkg::FIELD_BYTES_DEF,
   parameter int unsigned QUEUE_DEPTH = ufd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [15:0]      rsp_source_id,
   output logic [15:0]      rsp_dest_id,
   output logic [15:0]      rsp_command_code,
   output logic [15:0]      rsp_payload_length,
   output logic [7:0]       rsp_payload_byte,
   output logic [15:0]      rsp_payload_index,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);
   import ufd_pkg::*;

   logic      queue_full;
   logic      push_valid;
   entry_type push_entry;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   ufd_front #(
      .FIELD_BYTES (FIELD_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   ufd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   ufd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .pop_valid          (pop_valid),
      .pop_entry          (pop_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_source_id      (rsp_source_id),
      .rsp_dest_id        (rsp_dest_id),
      .rsp_command_code   (rsp_command_code),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index)
   );

endmodule

`default_nettype wire

// File: rtl/ufd_front.sv
// ----------------------------------------------------------------------------
// ufd_front
// Accepts received bytes, tracks the frame phase and queues at most one op per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ufd_front #(
   parameter int unsigned FIELD_BYTES = ufd_pkg::FIELD_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_rx_byte,
   input  wire logic              queue_full,
   output logic                   push_valid,
   output ufd_pkg::entry_type     push_entry
);
   import ufd_pkg::*;

   typedef enum logic [6:0] {
      PH_SOURCE  = 7'b0000001,
      PH_DEST    = 7'b0000010,
      PH_COMMAND = 7'b0000100,
      PH_LENGTH  = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_TAIL    = 7'b0100000,
      PH_IDLE    = 7'b1000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  prev_ff, prev_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_inc;
   logic [15:0] length_next;
   logic        accept;
   logic        sync;
   logic        word_done;

   assign req_ready   = !queue_full;
   assign accept      = req_valid && req_ready;
   assign count_inc   = count_ff + 16'd1;
   assign word_done   = (count_inc >= 16'(FIELD_BYTES));
   assign length_next = insert_byte(length_ff, req_rx_byte, count_ff);
   assign sync        = (phase_ff != PH_PAYLOAD) && (prev_ff == SYNC_FIRST)
                        && (req_rx_byte == SYNC_SECOND);

   always_comb begin
      phase_in   = phase_ff;
      prev_in    = prev_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      push_valid = 1'b0;
      push_entry = '{op: OP_CLEAR, data: req_rx_byte, index: count_ff, last: 1'b0};
      if (accept) begin
         prev_in = req_rx_byte;
         if (sync) begin
            phase_in   = PH_SOURCE;
            count_in   = '0;
            length_in  = '0;
            push_valid = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_SOURCE, PH_DEST, PH_COMMAND, PH_LENGTH: begin
                  push_valid = 1'b1;
                  count_in   = word_done ? 16'd0 : count_inc;
                  unique case (phase_ff)
                     PH_SOURCE: begin
                        push_entry.op = OP_SOURCE;
                        if (word_done) phase_in = PH_DEST;
                     end
                     PH_DEST: begin
                        push_entry.op = OP_DEST;
                        if (word_done) phase_in = PH_COMMAND;
                     end
                     PH_COMMAND: begin
                        push_entry.op = OP_COMMAND;
                        if (word_done) phase_in = PH_LENGTH;
                     end
                     default: begin
                        push_entry.op = OP_LENGTH;
                        length_in     = length_next;
                        if (word_done) begin
                           phase_in = (length_next != 16'd0) ? PH_PAYLOAD : PH_TAIL;
                        end
                     end
                  endcase
               end
               PH_PAYLOAD: begin
                  push_valid    = 1'b1;
                  push_entry.op = OP_PAYLOAD;
                  if (count_inc >= length_ff) begin
                     count_in = '0;
                     phase_in = PH_TAIL;
                  end else begin
                     count_in = count_inc;
                  end
               end
               PH_TAIL: begin
                  push_valid      = 1'b1;
                  push_entry.op   = OP_TAIL;
                  push_entry.last = word_done;
                  if (word_done) begin
                     count_in = '0;
                     phase_in = PH_IDLE;
                  end else begin
                     count_in = count_inc;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         prev_ff   <= '0;
         count_ff  <= '0;
         length_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         prev_ff   <= prev_in;
         count_ff  <= count_in;
         length_ff <= length_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ufd_queue.sv
// ----------------------------------------------------------------------------
// ufd_queue
// Short FIFO of classified ops between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ufd_queue #(
   parameter int unsigned DEPTH = ufd_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire ufd_pkg::entry_type  push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     pop_valid,
   output ufd_pkg::entry_type       pop_entry
);
   import ufd_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ufd_back.sv
// ----------------------------------------------------------------------------
// ufd_back
// Applies queued ops to the header words and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ufd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [15:0]         csr_wr_data,
   input  wire logic                pop_valid,
   input  wire ufd_pkg::entry_type  pop_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [1:0]               rsp_result_kind,
   output logic [15:0]              rsp_source_id,
   output logic [15:0]              rsp_dest_id,
   output logic [15:0]              rsp_command_code,
   output logic [15:0]              rsp_payload_length,
   output logic [7:0]               rsp_payload_byte,
   output logic [15:0]              rsp_payload_index
);
   import ufd_pkg::*;

   logic [15:0] tail_value_ff;
   logic [15:0] source_ff, source_in;
   logic [15:0] dest_ff, dest_in;
   logic [15:0] command_ff, command_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] tail_ff, tail_in;
   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] out_source_ff, out_dest_ff, out_command_ff, out_length_ff;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [15:0] out_index_ff, out_index_in;
   logic [15:0] field_next;
   logic        makes_result;
   logic        out_free;

   assign makes_result = (pop_entry.op == OP_PAYLOAD)
                         || ((pop_entry.op == OP_TAIL) && pop_entry.last);
   assign out_free     = !valid_ff || rsp_ready;
   assign pop          = pop_valid && (!makes_result || out_free);
   assign field_next   = insert_byte(tail_ff, pop_entry.data, pop_entry.index);

   always_comb begin
      source_in    = source_ff;
      dest_in      = dest_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      tail_in      = tail_ff;
      valid_in     = valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      out_byte_in  = out_byte_ff;
      out_index_in = out_index_ff;
      if (pop) begin
         case (pop_entry.op)
            OP_CLEAR: begin
               source_in  = '0;
               dest_in    = '0;
               command_in = '0;
               length_in  = '0;
               tail_in    = '0;
            end
            OP_SOURCE: source_in = insert_byte(source_ff, pop_entry.data, pop_entry.index);
            OP_DEST: dest_in = insert_byte(dest_ff, pop_entry.data, pop_entry.index);
            OP_COMMAND: begin
               command_in = insert_byte(command_ff, pop_entry.data, pop_entry.index);
            end
            OP_LENGTH: length_in = insert_byte(length_ff, pop_entry.data, pop_entry.index);
            OP_PAYLOAD: begin
               valid_in     = 1'b1;
               kind_in      = KIND_PAYLOAD;
               out_byte_in  = pop_entry.data;
               out_index_in = pop_entry.index;
            end
            OP_TAIL: begin
               tail_in = field_next;
               if (pop_entry.last) begin
                  valid_in     = 1'b1;
                  kind_in      = (field_next == tail_value_ff) ? KIND_TAIL_OK : KIND_TAIL_BAD;
                  out_byte_in  = '0;
                  out_index_in = '0;
               end
            end
            default: begin
               tail_in = tail_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_value_ff <= '0;
         source_ff     <= '0;
         dest_ff       <= '0;
         command_ff    <= '0;
         length_ff     <= '0;
         tail_ff       <= '0;
         valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tail_value_ff <= csr_wr_data;
         end
         source_ff  <= source_in;
         dest_ff    <= dest_in;
         command_ff <= command_in;
         length_ff  <= length_in;
         tail_ff    <= tail_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && makes_result) begin
         out_source_ff  <= source_ff;
         out_dest_ff    <= dest_ff;
         out_command_ff <= command_ff;
         out_length_ff  <= length_ff;
      end
      kind_ff      <= kind_in;
      out_byte_ff  <= out_byte_in;
      out_index_ff <= out_index_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_source_id      = out_source_ff;
   assign rsp_dest_id        = out_dest_ff;
   assign rsp_command_code   = out_command_ff;
   assign rsp_payload_length = out_length_ff;
   assign rsp_payload_byte   = out_byte_ff;
   assign rsp_payload_index  = out_index_ff;

endmodule

`default_nettype wire

// File: rtl/ufd_checker.sv
// ----------------------------------------------------------------------------
// ufd_checker
// Port-level checks on the deframer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ufd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_result_kind,
   input wire logic [15:0] rsp_payload_length,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic [15:0] rsp_payload_index
);
   import ufd_pkg::*;

   `UFD_ASSERT(a_hold_stalled_beat, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) && $stable(rsp_payload_index), "stalled beat changed")
   `UFD_ASSERT(a_tail_beat_no_data, clock, reset, rsp_valid && (rsp_result_kind != KIND_PAYLOAD) |-> (rsp_payload_byte == 8'd0) && (rsp_payload_index == 16'd0), "tail beat carries payload data")
   `UFD_ASSERT(a_index_below_length, clock, reset, rsp_valid && (rsp_result_kind == KIND_PAYLOAD) |-> rsp_payload_index < rsp_payload_length, "payload index beyond length")
   `UFD_ASSERT_ALWAYS(a_reset_drops_valid, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind uart_frame_deframer ufd_checker u_ufd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_payload_length (rsp_payload_length),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_payload_index  (rsp_payload_index)
);

`default_nettype wire
